>>> hw/rtl/slrg_pkg.sv
`default_nettype none

package slrg_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;

  // Lehmer generator constants: modulus 2^31-1 and multiplier
  localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam int unsigned LEHMER_MUL = 16807;

  // Item operation codes
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Result kind codes
  localparam logic KIND_INIT = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // Arithmetic unit modes
  localparam logic MODE_STEP = 1'b0;  // (a * 16807) mod (2^31-1)
  localparam logic MODE_SLOT = 1'b1;  // floor(a * depth / (2^31-1))

  typedef struct packed {
    logic        op;
    logic [30:0] table_seed;
    logic [30:0] stream_seed;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [30:0] random_value;
  } result_t;

  typedef struct packed {
    logic        mode;
    logic [30:0] operand;
  } mm_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/slrg_mulmod.sv
`default_nettype none

module slrg_mulmod #(
  parameter int unsigned TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire slrg_pkg::mm_req_t req,
  output logic [30:0]           res
);
  import slrg_pkg::*;

  localparam int unsigned DW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BW = (DW > 15) ? DW : 15;
  localparam int unsigned PW = 31 + BW;

  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic          mode_q;
  logic [BW-1:0] hi;
  logic [31:0]   sum;
  logic          wrap;
  logic [31:0]   step_val;
  logic [30:0]   quot;

  assign mul_b = (req.mode == MODE_STEP) ? BW'(LEHMER_MUL) : BW'(TABLE_DEPTH);

  // Stage one: multiply
  always_ff @(posedge clk) begin
    prod   <= PW'(req.operand) * PW'(mul_b);
    mode_q <= req.mode;
  end

  // Stage two: fold the high part back in, since 2^31 is 1 modulo 2^31-1
  assign hi       = prod[PW-1:31];
  assign sum      = {1'b0, prod[30:0]} + 32'(hi);
  assign wrap     = (sum >= {1'b0, LEHMER_MOD});
  assign step_val = wrap ? (sum - {1'b0, LEHMER_MOD}) : sum;
  assign quot     = 31'(hi) + 31'(wrap);

  always_ff @(posedge clk) begin
    res <= (mode_q == MODE_STEP) ? step_val[30:0] : quot;
  end

endmodule

`default_nettype wire

>>> hw/rtl/shuffled_lehmer_random_generator.sv
`default_nettype none
// Draw: the item steps through the slot, seed, read and write states to the finish state, which registers the result.
// Initialize: the TABLE_DEPTH+1 Lehmer steps run through the shared multiply/fold unit,
//   one after another, each step taking the result of the one before as its operand.
// One item at a time: item_stall is high from the transfer until the result is registered.
// Reset (rst, synchronous): sequencer idle, output empty, stream seed 1, last pick 0.
//   The shuffle table is not cleared; draws before an initialize read undefined entries.

module shuffled_lehmer_random_generator #(
  parameter int unsigned TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire slrg_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output slrg_pkg::result_t      result
);
  import slrg_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_INIT_MUL   = 4'd1;
  localparam logic [3:0] S_INIT_WAIT  = 4'd2;
  localparam logic [3:0] S_INIT_STORE = 4'd3;
  localparam logic [3:0] S_DRAW_SLOT  = 4'd4;
  localparam logic [3:0] S_DRAW_SEED  = 4'd5;
  localparam logic [3:0] S_DRAW_READ  = 4'd6;
  localparam logic [3:0] S_DRAW_WRITE = 4'd7;
  localparam logic [3:0] S_FINISH     = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] idx;          // table fill position during initialize
  logic [30:0]   walk_seed;    // table seed held for the first step
  logic [30:0]   stream_hold;  // stream seed held until the walk ends
  logic [30:0]   seed;         // current stream seed
  logic [30:0]   last_pick;
  logic [AW-1:0] slot;
  logic          res_kind;
  logic [30:0]   res_value;

  mm_req_t       mm_req;
  logic [30:0]   mm_res;

  logic [30:0]   mem [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [30:0]   mem_rdata;
  logic [AW-1:0] slot_pick;

  logic          item_xfer;
  logic          out_free;

  assign item_stall = (state != S_IDLE);
  assign item_xfer  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // Shared multiply/fold unit: a request is answered through the product and result registers
  slrg_mulmod #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mulmod (
    .clk (clk),
    .req (mm_req),
    .res (mm_res)
  );

  always_comb begin
    case (state)
      S_INIT_MUL:   mm_req = '{mode: MODE_STEP, operand: walk_seed};
      S_INIT_STORE: mm_req = '{mode: MODE_STEP, operand: mm_res};     // chain the walk
      S_DRAW_SLOT:  mm_req = '{mode: MODE_SLOT, operand: last_pick};
      S_DRAW_SEED:  mm_req = '{mode: MODE_STEP, operand: seed};
      default:      mm_req = '{mode: MODE_STEP, operand: walk_seed};
    endcase
  end

  // Clamp the slot quotient to the last entry; only reachable with an out-of-range pick
  assign slot_pick = (mm_res > 31'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : mm_res[AW-1:0];

  // Table write port: fill during initialize, replace the picked entry on a draw
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    case (state)
      S_INIT_STORE: begin
        mem_we    = (idx < CW'(TABLE_DEPTH));
        mem_waddr = idx[AW-1:0];
      end
      S_DRAW_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
      end
      default: begin
        mem_we    = 1'b0;
        mem_waddr = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mm_res;
    end
    mem_rdata <= mem[slot_pick];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seed      <= 31'd1;
      last_pick <= '0;
      idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_xfer) begin
            walk_seed   <= item.table_seed;
            stream_hold <= item.stream_seed;
            idx         <= '0;
            state       <= (item.op == OP_INIT) ? S_INIT_MUL : S_DRAW_SLOT;
          end
        end
        S_INIT_MUL: begin
          state <= S_INIT_WAIT;
        end
        S_INIT_WAIT: begin
          state <= S_INIT_STORE;
        end
        S_INIT_STORE: begin
          if (idx < CW'(TABLE_DEPTH)) begin
            idx   <= idx + CW'(1);
            state <= S_INIT_WAIT;
          end else begin
            // extra step past the table becomes the first pick
            last_pick <= mm_res;
            seed      <= stream_hold;
            res_kind  <= KIND_INIT;
            res_value <= '0;
            state     <= S_FINISH;
          end
        end
        S_DRAW_SLOT: begin
          state <= S_DRAW_SEED;
        end
        S_DRAW_SEED: begin
          state <= S_DRAW_READ;
        end
        S_DRAW_READ: begin
          slot  <= slot_pick;
          state <= S_DRAW_WRITE;
        end
        S_DRAW_WRITE: begin
          seed      <= mm_res;
          last_pick <= mem_rdata;
          res_kind  <= KIND_DRAW;
          // drop one so the fraction stays below one; hold zero at zero
          res_value <= (mem_rdata == '0) ? '0 : (mem_rdata - 31'd1);
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      result.kind         <= res_kind;
      result.random_value <= res_value;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/slrg_checker.sv
`default_nettype none

module slrg_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire slrg_pkg::result_t result
);
  import slrg_pkg::*;

  // One item at a time: the block is busy right after taking an item
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item taken while previous item in progress");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A pending result is not dropped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result dropped");

  // Initialize results carry zero
  a_init_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_INIT) |-> (result.random_value == '0))
    else $error("initialize result not zero");

  // Drawn values lie below 2^31-2
  a_draw_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_DRAW) |->
      (result.random_value != 31'h7FFF_FFFF && result.random_value != 31'h7FFF_FFFE))
    else $error("drawn value out of range");

endmodule

bind shuffled_lehmer_random_generator slrg_checker u_slrg_checker (.*);

`default_nettype wire
